// File: rtl/core/tlms_pkg.sv
package tlms_pkg;

    localparam int unsigned NUM_BUTTONS = 5;
    localparam int unsigned TICK_W      = 17;
    localparam int unsigned LOCKOUT_W   = 10;
    localparam int unsigned CFG_IDX_W   = 3;

    typedef enum logic [1:0] {
        MODE_LIGHT  = 2'd0,
        MODE_HEAVY  = 2'd1,
        MODE_NIGHT  = 2'd2,
        MODE_MANUAL = 2'd3
    } t_mode;

    // Phase codes of a timed cycle. Night mode uses only the first two.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // Button positions within the level word.
    localparam int unsigned BTN_TOGGLE = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_GREEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_YELLOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVY_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVY_YELLOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVY_RED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = 3'd7;

    localparam logic [TICK_W-1:0]    RST_LIGHT_GREEN  = 17'd20000;
    localparam logic [TICK_W-1:0]    RST_LIGHT_YELLOW = 17'd10000;
    localparam logic [TICK_W-1:0]    RST_LIGHT_RED    = 17'd30000;
    localparam logic [TICK_W-1:0]    RST_HEAVY_GREEN  = 17'd60000;
    localparam logic [TICK_W-1:0]    RST_HEAVY_YELLOW = 17'd10000;
    localparam logic [TICK_W-1:0]    RST_HEAVY_RED    = 17'd70000;
    localparam logic [TICK_W-1:0]    RST_BLINK_HALF   = 17'd1000;
    localparam logic [LOCKOUT_W-1:0] RST_LOCKOUT      = 10'd50;

    // Phase lengths handed to the sequencer.
    typedef struct packed {
        logic [TICK_W-1:0] light_green;
        logic [TICK_W-1:0] light_yellow;
        logic [TICK_W-1:0] light_red;
        logic [TICK_W-1:0] heavy_green;
        logic [TICK_W-1:0] heavy_yellow;
        logic [TICK_W-1:0] heavy_red;
        logic [TICK_W-1:0] blink_half;
    } t_phase_cfg;

    // Button state after this tick's press has been applied.
    typedef struct packed {
        t_mode                  sel_mode;
        logic                   man_dir;
        logic [NUM_BUTTONS-1:0] indicators;
    } t_press_state;

    typedef struct packed {
        logic  red;
        logic  yellow;
        logic  green;
        t_mode shown_mode;
    } t_lamps;

endpackage

// File: rtl/core/tlms_press.sv
module tlms_press
    import tlms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic [NUM_BUTTONS-1:0] i_levels,
    input  logic [LOCKOUT_W-1:0]   i_lockout,
    output t_press_state           o_next
);

    localparam logic [LOCKOUT_W-1:0] SINCE_MAX = {LOCKOUT_W{1'b1}};

    logic [NUM_BUTTONS-1:0] r_prev_levels;
    logic [LOCKOUT_W-1:0]   r_since;
    t_press_state           r_state;

    logic [NUM_BUTTONS-1:0] edges;
    logic                   accepted;
    logic [LOCKOUT_W-1:0]   n_since;
    t_press_state           n_state;

    assign edges = i_levels & ~r_prev_levels;

    always_comb begin
        n_state  = r_state;
        accepted = 1'b0;
        if (edges != '0 && r_since >= i_lockout) begin
            accepted = 1'b1;
            // The lowest-numbered rising button wins.
            priority if (edges[0]) begin
                n_state.sel_mode      = MODE_LIGHT;
                n_state.indicators[0] = 1'b1;
            end else if (edges[1]) begin
                n_state.sel_mode      = MODE_HEAVY;
                n_state.indicators[1] = 1'b1;
            end else if (edges[2]) begin
                n_state.sel_mode      = MODE_NIGHT;
                n_state.indicators[2] = 1'b1;
            end else if (edges[3]) begin
                n_state.sel_mode      = MODE_MANUAL;
                n_state.indicators[3] = 1'b1;
            end else begin
                n_state.man_dir               = ~r_state.man_dir;
                n_state.indicators[BTN_TOGGLE] = 1'b1;
            end
        end
        if (accepted) begin
            n_since = '0;
        end else if (r_since != SINCE_MAX) begin
            n_since = r_since + 1'b1;
        end else begin
            n_since = r_since;
        end
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels <= '0;
            r_since       <= '0;
            r_state       <= '{sel_mode: MODE_LIGHT, man_dir: 1'b0, indicators: '0};
        end else if (i_advance) begin
            r_prev_levels <= i_levels;
            r_since       <= n_since;
            r_state       <= n_state;
        end
    end

endmodule

// File: rtl/core/tlms_phase.sv
module tlms_phase
    import tlms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_phase_cfg i_cfg,
    input  t_mode      i_sel_mode,
    input  logic       i_man_dir,
    output t_lamps     o_lamps
);

    t_mode             r_active;
    logic [1:0]        r_phase;
    logic [TICK_W-1:0] r_elapsed;

    t_mode             n_active;
    logic [1:0]        n_phase;
    logic [TICK_W-1:0] n_elapsed;

    logic [1:0]        last_ph;
    logic [1:0]        ph;
    logic [TICK_W-1:0] len;
    logic [TICK_W:0]   elapsed_inc;
    logic              ph_done;

    always_comb begin
        unique case (r_active)
            MODE_NIGHT: last_ph = PH_SECOND;
            default:    last_ph = PH_THIRD;
        endcase
        ph = (r_phase > last_ph) ? last_ph : r_phase;

        unique case (r_active)
            MODE_LIGHT: begin
                unique case (ph)
                    PH_FIRST:  len = i_cfg.light_green;
                    PH_SECOND: len = i_cfg.light_yellow;
                    default:   len = i_cfg.light_red;
                endcase
            end
            MODE_HEAVY: begin
                unique case (ph)
                    PH_FIRST:  len = i_cfg.heavy_green;
                    PH_SECOND: len = i_cfg.heavy_yellow;
                    default:   len = i_cfg.heavy_red;
                endcase
            end
            default: len = i_cfg.blink_half;
        endcase

        elapsed_inc = {1'b0, r_elapsed} + 1'b1;
        ph_done     = elapsed_inc >= {1'b0, len};

        o_lamps.shown_mode = r_active;
        o_lamps.red        = 1'b0;
        o_lamps.yellow     = 1'b0;
        o_lamps.green      = 1'b0;
        n_active           = r_active;
        n_phase            = r_phase;
        n_elapsed          = r_elapsed;

        if (r_active == MODE_MANUAL) begin
            o_lamps.red   = i_man_dir;
            o_lamps.green = ~i_man_dir;
            if (i_sel_mode != r_active) begin
                n_active  = i_sel_mode;
                n_phase   = PH_FIRST;
                n_elapsed = '0;
            end
        end else begin
            if (r_active == MODE_NIGHT) begin
                o_lamps.yellow = (ph == PH_FIRST);
            end else begin
                o_lamps.green  = (ph == PH_FIRST);
                o_lamps.yellow = (ph == PH_SECOND);
                o_lamps.red    = (ph == PH_THIRD);
            end
            if (ph_done) begin
                n_elapsed = '0;
                // The selected mode takes over only once the cycle is complete.
                if (ph >= last_ph) begin
                    n_active = i_sel_mode;
                    n_phase  = PH_FIRST;
                end else begin
                    n_phase = ph + 1'b1;
                end
            end else begin
                n_elapsed = elapsed_inc[TICK_W-1:0];
                n_phase   = ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= MODE_LIGHT;
            r_phase   <= PH_FIRST;
            r_elapsed <= '0;
        end else if (i_advance) begin
            r_active  <= n_active;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

// File: rtl/core/traffic_light_mode_sequencer.sv
// Traffic light mode sequencer.
// Input channel: one request per millisecond tick, carrying the five button
// levels (light, heavy, night, manual, toggle) on i_button_levels.
// Output channel: one result per request with the three lamp bits, the
// sticky press indicators and the mode that drives the lamps on that tick.
// A request is taken on an edge where its valid is high and its stall low.
// The result of a request is shown on the output register in the cycle
// after it is taken. One request is taken per cycle while o_in_stall is low;
// all state is updated by one pass of logic over the mode, phase and
// lockout counters.
// When the receiver stalls, the result is held and the input stalls only
// if the output register is still full, so no result is lost or repeated.
// Configuration writes take effect on the edge of i_cfg_we and should only
// be made while no request is in flight.
// Synchronous active-low reset restores the default phase lengths and
// lockout, selects light-traffic mode at its first phase and clears the
// indicators, the button history and the output valid flag.
module traffic_light_mode_sequencer
    import tlms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [NUM_BUTTONS-1:0] i_button_levels,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_lamp_red,
    output logic                   o_lamp_yellow,
    output logic                   o_lamp_green,
    output logic [NUM_BUTTONS-1:0] o_press_indicators,
    output logic [1:0]             o_running_mode,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [TICK_W-1:0]      i_cfg_data
);

    t_phase_cfg             r_cfg;
    logic [LOCKOUT_W-1:0]   r_lockout;

    logic                   r_out_valid;
    t_lamps                 r_lamps;
    logic [NUM_BUTTONS-1:0] r_indicators;

    logic                   advance;
    t_press_state           press_next;
    t_lamps                 lamps;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign advance    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_green  <= RST_LIGHT_GREEN;
            r_cfg.light_yellow <= RST_LIGHT_YELLOW;
            r_cfg.light_red    <= RST_LIGHT_RED;
            r_cfg.heavy_green  <= RST_HEAVY_GREEN;
            r_cfg.heavy_yellow <= RST_HEAVY_YELLOW;
            r_cfg.heavy_red    <= RST_HEAVY_RED;
            r_cfg.blink_half   <= RST_BLINK_HALF;
            r_lockout          <= RST_LOCKOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LIGHT_GREEN:  r_cfg.light_green  <= i_cfg_data;
                REG_LIGHT_YELLOW: r_cfg.light_yellow <= i_cfg_data;
                REG_LIGHT_RED:    r_cfg.light_red    <= i_cfg_data;
                REG_HEAVY_GREEN:  r_cfg.heavy_green  <= i_cfg_data;
                REG_HEAVY_YELLOW: r_cfg.heavy_yellow <= i_cfg_data;
                REG_HEAVY_RED:    r_cfg.heavy_red    <= i_cfg_data;
                REG_BLINK_HALF:   r_cfg.blink_half   <= i_cfg_data;
                REG_LOCKOUT:      r_lockout          <= i_cfg_data[LOCKOUT_W-1:0];
                default:          r_lockout          <= r_lockout;
            endcase
        end
    end

    tlms_press u_press (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_levels  (i_button_levels),
        .i_lockout (r_lockout),
        .o_next    (press_next)
    );

    tlms_phase u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_cfg      (r_cfg),
        .i_sel_mode (press_next.sel_mode),
        .i_man_dir  (press_next.man_dir),
        .o_lamps    (lamps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lamps      <= lamps;
            r_indicators <= press_next.indicators;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_lamp_red         = r_lamps.red;
    assign o_lamp_yellow      = r_lamps.yellow;
    assign o_lamp_green       = r_lamps.green;
    assign o_press_indicators = r_indicators;
    assign o_running_mode     = r_lamps.shown_mode;

`ifndef ASSERT_OFF
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while output register is empty");

    a_lamps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_lamp_red, o_lamp_yellow, o_lamp_green}))
        else $error("more than one lamp lit");

    a_night_yellow_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_running_mode == MODE_NIGHT) |-> (!o_lamp_red && !o_lamp_green))
        else $error("red or green lit in night mode");

    a_manual_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_running_mode == MODE_MANUAL)
            |-> (!o_lamp_yellow && (o_lamp_red != o_lamp_green)))
        else $error("manual mode lamps not steady red or green");

    a_timed_one_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_running_mode == MODE_LIGHT || o_running_mode == MODE_HEAVY))
            |-> $onehot({o_lamp_red, o_lamp_yellow, o_lamp_green}))
        else $error("timed cycle shows no lamp");
`endif

endmodule

// File: tb/traffic_light_mode_sequencer_tb.sv
module traffic_light_mode_sequencer_tb
    import tlms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   red;
        logic                   yellow;
        logic                   green;
        logic [NUM_BUTTONS-1:0] ind;
        t_mode                  mode;
    } t_tick_lamps;

    typedef struct packed {
        logic        pinned;
        t_tick_lamps lamps;
    } t_typed_lamps;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [NUM_BUTTONS-1:0] levels;
        logic [CFG_IDX_W-1:0]   idx;
        logic [TICK_W-1:0]      data;
        logic                   pinned;
        t_tick_lamps            lamps;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [NUM_BUTTONS-1:0] i_button_levels;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_lamp_red;
    logic                   o_lamp_yellow;
    logic                   o_lamp_green;
    logic [NUM_BUTTONS-1:0] o_press_indicators;
    logic [1:0]             o_running_mode;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [TICK_W-1:0]      i_cfg_data;

    traffic_light_mode_sequencer i_dut (.*);

    // Shadow of the sequencer state.
    logic [TICK_W-1:0]      len_reg [7];
    logic [LOCKOUT_W-1:0]   lockout_reg;
    t_mode                  sel_mode;
    t_mode                  act_mode;
    logic [1:0]             phase_cnt;
    logic [TICK_W-1:0]      elapsed;
    logic [LOCKOUT_W-1:0]   since_press;
    logic                   man_dir;
    logic [NUM_BUTTONS-1:0] ind_bits;
    logic [NUM_BUTTONS-1:0] prev_lv;

    t_tick_lamps  pending_lamps_q [$];
    t_typed_lamps typed_lamps_q [$];
    int unsigned  mismatch_count = 0;
    int           burst_left = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_tick_lamps advance_tick(logic [NUM_BUTTONS-1:0] lv);
        t_tick_lamps            r;
        logic [NUM_BUTTONS-1:0] edges;
        logic [1:0]             last;
        logic [1:0]             p;
        logic [TICK_W-1:0]      len;
        logic                   taken;
        edges = lv & ~prev_lv;
        prev_lv = lv;
        taken = 1'b0;
        r = '0;
        if (edges != '0 && since_press >= lockout_reg) begin
            // Lowest-numbered rising button wins.
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (!taken && edges[b]) begin
                    taken = 1'b1;
                    ind_bits[b] = 1'b1;
                    if (b == BTN_TOGGLE)
                        man_dir = ~man_dir;
                    else
                        sel_mode = t_mode'(b);
                end
            end
        end
        if (taken)
            since_press = '0;
        else if (since_press != '1)
            since_press++;
        r.mode = act_mode;
        r.ind = ind_bits;
        if (act_mode == MODE_MANUAL) begin
            r.red = man_dir;
            r.green = ~man_dir;
            if (sel_mode != act_mode) begin
                act_mode = sel_mode;
                phase_cnt = PH_FIRST;
                elapsed = '0;
            end
        end else begin
            last = (act_mode == MODE_NIGHT) ? PH_SECOND : PH_THIRD;
            p = (phase_cnt > last) ? last : phase_cnt;
            case (act_mode)
                MODE_LIGHT: len = len_reg[REG_LIGHT_GREEN + p];
                MODE_HEAVY: len = len_reg[REG_HEAVY_GREEN + p];
                default:    len = len_reg[REG_BLINK_HALF];
            endcase
            if (act_mode == MODE_NIGHT) begin
                r.yellow = (p == PH_FIRST);
            end else begin
                r.green = (p == PH_FIRST);
                r.yellow = (p == PH_SECOND);
                r.red = (p == PH_THIRD);
            end
            // A phase of length zero still lasts one tick.
            if ({1'b0, elapsed} + 1'b1 >= {1'b0, len}) begin
                elapsed = '0;
                if (p >= last) begin
                    act_mode = sel_mode;
                    phase_cnt = PH_FIRST;
                end else begin
                    phase_cnt = p + 2'd1;
                end
            end else begin
                elapsed++;
                phase_cnt = p;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : lamp_monitor
        t_tick_lamps  got;
        t_tick_lamps  want;
        t_typed_lamps typed;
        if (!i_rst_n) begin
            len_reg[REG_LIGHT_GREEN]  = RST_LIGHT_GREEN;
            len_reg[REG_LIGHT_YELLOW] = RST_LIGHT_YELLOW;
            len_reg[REG_LIGHT_RED]    = RST_LIGHT_RED;
            len_reg[REG_HEAVY_GREEN]  = RST_HEAVY_GREEN;
            len_reg[REG_HEAVY_YELLOW] = RST_HEAVY_YELLOW;
            len_reg[REG_HEAVY_RED]    = RST_HEAVY_RED;
            len_reg[REG_BLINK_HALF]   = RST_BLINK_HALF;
            lockout_reg = RST_LOCKOUT;
            sel_mode = MODE_LIGHT;
            act_mode = MODE_LIGHT;
            phase_cnt = PH_FIRST;
            elapsed = '0;
            since_press = '0;
            man_dir = 1'b0;
            ind_bits = '0;
            prev_lv = '0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_lamp_red, o_lamp_yellow, o_lamp_green, o_press_indicators,
                        t_mode'(o_running_mode)};
                if (pending_lamps_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_lamps_q.pop_front();
                    check_field("lamp_red", 32'(want.red), 32'(got.red));
                    check_field("lamp_yellow", 32'(want.yellow), 32'(got.yellow));
                    check_field("lamp_green", 32'(want.green), 32'(got.green));
                    check_field("press_indicators", 32'(want.ind), 32'(got.ind));
                    check_field("running_mode", 32'(want.mode), 32'(got.mode));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_LOCKOUT)
                    lockout_reg = i_cfg_data[LOCKOUT_W-1:0];
                else
                    len_reg[i_cfg_index] = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                want = advance_tick(i_button_levels);
                typed = typed_lamps_q.pop_front();
                pending_lamps_q.push_back(typed.pinned ? typed.lamps : want);
            end
        end
    end

    // Receiver: segments of free flow, light and heavy stalling, and now and
    // then a long hold-off that backs the block up into its input.
    initial begin
        int unsigned seg_count;
        int unsigned kind;
        int unsigned span;
        seg_count = 0;
        i_out_stall <= 1'b0;
        forever begin
            seg_count++;
            if (seg_count % 8 == 3) begin
                span = $urandom_range(40, 90);
                repeat (span) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                kind = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
                repeat (span) begin
                    @(posedge i_clk);
                    case (kind)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                        default: i_out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    task automatic offer_tick(logic [NUM_BUTTONS-1:0] lv, logic pinned, t_tick_lamps lamps);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        typed_lamps_q.push_back(t_typed_lamps'{pinned, lamps});
        i_cfg_we <= 1'b0;
        i_in_valid <= 1'b1;
        i_button_levels <= lv;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Waits until every request has its result; checked on the falling edge
    // so the monitor has already run for the rising edge.
    task automatic drain();
        i_in_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        do @(negedge i_clk); while (pending_lamps_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    function automatic t_row row_tick(logic [NUM_BUTTONS-1:0] lv);
        return '{ROW_TICK, lv, '0, '0, 1'b0, '0};
    endfunction

    function automatic t_row row_pin(logic [NUM_BUTTONS-1:0] lv, logic red, logic yellow,
                                     logic green, logic [NUM_BUTTONS-1:0] ind, t_mode mode);
        return '{ROW_TICK, lv, '0, '0, 1'b1, '{red, yellow, green, ind, mode}};
    endfunction

    function automatic t_row row_cfg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
        return '{ROW_CFG, '0, idx, data, 1'b0, '0};
    endfunction

    initial begin
        t_row                   rows [$];
        logic [TICK_W-1:0]      len_pick;
        logic [TICK_W-1:0]      lock_pick;
        logic [NUM_BUTTONS-1:0] held_lv;
        int unsigned            hold_left;
        int unsigned            roll;
        held_lv = '0;
        hold_left = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_button_levels <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            row_pin(5'h00, 1'b0, 1'b0, 1'b1, 5'h00, MODE_LIGHT),
            // All buttons rise inside the lockout that follows reset.
            row_pin(5'h1F, 1'b0, 1'b0, 1'b1, 5'h00, MODE_LIGHT),
            row_tick(5'h00),
            row_cfg(REG_LOCKOUT, 17'd0),
            row_cfg(REG_LIGHT_GREEN, 17'd0),
            row_cfg(REG_LIGHT_YELLOW, 17'd1),
            row_cfg(REG_LIGHT_RED, 17'd2),
            row_cfg(REG_HEAVY_GREEN, 17'd1),
            row_cfg(REG_HEAVY_YELLOW, 17'd1),
            row_cfg(REG_HEAVY_RED, 17'd1),
            row_cfg(REG_BLINK_HALF, 17'd2),
            // Green was cut below its elapsed count, and the light button wins.
            row_pin(5'h1F, 1'b0, 1'b0, 1'b1, 5'h01, MODE_LIGHT),
            row_tick(5'h1E),
            row_tick(5'h00),
            row_tick(5'h02),
            row_tick(5'h00),
            row_tick(5'h04),
            row_tick(5'h00),
            row_tick(5'h10),
            row_tick(5'h00),
            row_tick(5'h08),
            row_tick(5'h00),
            row_tick(5'h00),
            row_tick(5'h00),
            row_tick(5'h00),
            row_tick(5'h10),
            row_tick(5'h00),
            row_cfg(REG_LOCKOUT, 17'h1FFFF),
            row_cfg(REG_HEAVY_RED, 17'h1FFFF),
            row_cfg(REG_BLINK_HALF, 17'h1FFFF),
            row_tick(5'h01),
            row_tick(5'h02),
            row_tick(5'h00)
        };
        foreach (rows[n]) begin
            if (rows[n].kind == ROW_CFG) begin
                drain();
                cfg_write(rows[n].idx, rows[n].data);
            end else begin
                offer_tick(rows[n].levels, rows[n].pinned, rows[n].lamps);
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            for (int r = REG_LIGHT_GREEN; r <= REG_BLINK_HALF; r++) begin
                case (ph)
                    0:       len_pick = 17'd1;
                    1:       len_pick = 17'd0;
                    2, 3:    len_pick = TICK_W'($urandom_range(1, 12));
                    4: begin
                        case ($urandom_range(0, 3))
                            0:       len_pick = 17'd0;
                            1:       len_pick = 17'd1;
                            2:       len_pick = 17'h1FFFF;
                            default: len_pick = TICK_W'($urandom_range(1, 30));
                        endcase
                    end
                    5:       len_pick = TICK_W'($urandom_range(1, 40));
                    default: len_pick = TICK_W'($urandom_range(1, 8));
                endcase
                cfg_write(r[CFG_IDX_W-1:0], len_pick);
            end
            case (ph)
                0, 1:    lock_pick = 17'd0;
                2:       lock_pick = TICK_W'($urandom_range(0, 8));
                3:       lock_pick = 17'h1FFFF;
                4:       lock_pick = TICK_W'($urandom_range(0, 20));
                default: lock_pick = TICK_W'($urandom_range(0, 3));
            endcase
            cfg_write(REG_LOCKOUT, lock_pick);
            for (int k = 0; k < 250; k++) begin
                // Mostly clean single presses held a few ticks, some chords.
                if (hold_left == 0) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55)
                        held_lv = '0;
                    else if (roll < 85)
                        held_lv = 5'h01 << $urandom_range(0, NUM_BUTTONS - 1);
                    else
                        held_lv = NUM_BUTTONS'($urandom_range(0, 31));
                    hold_left = $urandom_range(1, 4);
                end
                hold_left--;
                offer_tick(held_lv, 1'b0, '0);
            end
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tlms_pkg.sv
rtl/core/tlms_press.sv
rtl/core/tlms_phase.sv
rtl/core/traffic_light_mode_sequencer.sv
tb/traffic_light_mode_sequencer_tb.sv
